// File: rtl/sls_pkg.sv
package sls_pkg;

   // Store depth, value width and count widths
   localparam int Capacity = 16;
   localparam int ValueWidth = 32;
   localparam int CountWidth = $clog2(Capacity + 1);
   localparam int EntryCountWidth = 5;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_SEARCH = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_POP    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef logic signed [ValueWidth-1:0] value_type;

   // Broadcast to every cell of the chain
   typedef struct packed {
      logic       write_en;
      action_type action;
      value_type  value;
   } cell_ctl_type;

   // What a cell shows its right-hand neighbour
   typedef struct packed {
      value_type entry;
      logic      lt;
   } cell_link_type;

endpackage

// File: rtl/sls_if.sv
interface sls_req_if;
   import sls_pkg::*;

   logic       valid;
   logic       ready;
   action_type action;
   value_type  value;

   modport source (output valid, output action, output value, input ready);
   modport sink (input valid, input action, input value, output ready);
endinterface

interface sls_rsp_if;
   import sls_pkg::*;

   logic                       valid;
   logic                       ready;
   status_type                 status;
   value_type                  removed_value;
   logic [EntryCountWidth-1:0] entry_count;

   modport source (output valid, output status, output removed_value,
                   output entry_count, input ready);
   modport sink (input valid, input status, input removed_value,
                 input entry_count, output ready);
endinterface

// File: rtl/sls_cell.sv
module sls_cell (
   input  logic                  clock,
   input  sls_pkg::cell_ctl_type ctl,
   input  logic                  occupied,
   input  sls_pkg::cell_link_type left,
   input  sls_pkg::value_type    right_entry,
   output sls_pkg::cell_link_type link,
   output logic                  hit
);
   import sls_pkg::*;

   value_type entry_ff;
   value_type entry_in;
   logic      lt;

   // Compare the held entry with the broadcast value
   assign lt = occupied && (entry_ff < ctl.value);
   assign hit = occupied && (entry_ff == ctl.value) && left.lt;
   assign link.entry = entry_ff;
   assign link.lt = lt;

   // Keep, take the new word, or shift from a neighbour
   always_comb begin
      entry_in = entry_ff;
      case (ctl.action)
         ACT_INSERT: begin
            if (!lt) begin
               entry_in = left.lt ? ctl.value : left.entry;
            end
         end
         ACT_DELETE: begin
            if (!lt) begin
               entry_in = right_entry;
            end
         end
         ACT_POP: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.write_en) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// File: rtl/sorted_list_store.sv
// Sorted store of up to Capacity signed 32-bit values, ascending, duplicates
// allowed, built as a chain of cells that each compare against a broadcast
// value and shift to a neighbour in the same cycle.
// req channel: action (insert, search, delete value, pop smallest) and value.
// rsp channel: status, removed value (zero unless delete or pop succeeds)
// and the entry count after the action, one word per request word.
// The response word appears in the cycle after the request is taken.
// Throughput: one word per cycle; every action finishes in the cycle that
// accepts it, set by the single compare-and-shift step of the cell chain.
// The response sits in an output register; req_ready stays high while that
// register is empty or is being taken, so a stalled receiver holds the
// pending response and stalls the requester after one word.
// Reset (synchronous, active high) empties the store and drops any pending
// response; cell contents are not cleared, only the count is.
// Full insert reports full, delete or pop on an empty store reports empty,
// delete of a missing value reports not found; none of these changes state.
module sorted_list_store (
   input logic         clock,
   input logic         reset,
   sls_req_if.sink     req,
   sls_rsp_if.source   rsp
);
   import sls_pkg::*;

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  rsp_valid_ff;
   status_type            status_ff;
   status_type            status_in;
   value_type             removed_ff;
   value_type             removed_in;

   cell_ctl_type          ctl;
   cell_link_type         links [Capacity];
   logic [Capacity-1:0]   hits;
   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  found;
   logic                  change;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept = req.valid && req.ready;
   assign full = (count_ff == CountWidth'(Capacity));
   assign empty = (count_ff == '0);
   assign found = |hits;

   // Build the chain of cells
   genvar g;
   generate
      for (g = 0; g < Capacity; g++) begin : g_cell
         cell_link_type     left_link;
         value_type         right_val;
         logic              occ;

         assign occ = (CountWidth'(g) < count_ff);
         if (g == 0) begin : g_head
            assign left_link.entry = req.value;
            assign left_link.lt = 1'b1;
         end else begin : g_body
            assign left_link = links[g-1];
         end
         if (g == Capacity - 1) begin : g_tail
            assign right_val = links[g].entry;
         end else begin : g_inner
            assign right_val = links[g+1].entry;
         end

         sls_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (occ),
            .left        (left_link),
            .right_entry (right_val),
            .link        (links[g]),
            .hit         (hits[g])
         );
      end
   endgenerate

   // Decide the outcome of the offered word
   always_comb begin
      status_in = ST_OK;
      removed_in = '0;
      change = 1'b0;
      count_in = count_ff;
      unique case (req.action)
         ACT_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               change = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_SEARCH: begin
            status_in = found ? ST_OK : ST_NOT_FOUND;
         end
         ACT_DELETE: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (!found) begin
               status_in = ST_NOT_FOUND;
            end else begin
               change = 1'b1;
               removed_in = req.value;
               count_in = count_ff - 1'b1;
            end
         end
         ACT_POP: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               change = 1'b1;
               removed_in = links[0].entry;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   assign ctl.write_en = accept && change;
   assign ctl.action = req.action;
   assign ctl.value = req.value;

   // Hold count and response word
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         status_ff <= status_in;
         removed_ff <= removed_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = status_ff;
   assign rsp.removed_value = removed_ff;
   assign rsp.entry_count = EntryCountWidth'(count_ff);

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(Capacity))
      else $error("entry count above capacity");

   a_hit_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hits))
      else $error("more than one first-equal cell");

   a_count_on_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("count moved without an accepted word");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp.entry_count == EntryCountWidth'(count_ff)))
      else $error("response count out of step with store");

endmodule
